// ----- rtl/core/frame_delta_reference_blend_top_macros.svh -----
// assertion macros for the frame delta / reference blend block
// no dependencies; taken in by the top level
`ifndef FRAME_DELTA_REFERENCE_BLEND_TOP_MACROS_SVH
`define FRAME_DELTA_REFERENCE_BLEND_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define FDRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FDRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FDRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FDRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/fdrb_pkg.sv -----
// types, constants and lookup tables of the frame delta / reference blend block
// no dependencies; used by every other file but the macros header and fdrb_delta_if
`timescale 1ns / 1ps
package fdrb_pkg;

	localparam int IDX_W        = 20;
	localparam int FRAME_PIXELS = 1048576;
	localparam int MEM_DEPTH    = (FRAME_PIXELS > (1 << IDX_W)) ? (1 << IDX_W) : FRAME_PIXELS;
	localparam int ADDR_W       = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam int LANES = 3;
	localparam int CH_W  = 8;
	localparam int ACC_W = 16;
	localparam int PIX_W = LANES * CH_W;
	localparam int ACCS_W = LANES * ACC_W;
	localparam int SUM_W = 23;

	// request codes
	localparam logic REQ_COMPARE = 1'b0;
	localparam logic REQ_LOAD    = 1'b1;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_DELTAS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_BLEND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENCY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_ENABLE = 3'd4;

	localparam logic       RST_COLOUR_MODE  = 1'b1;
	localparam logic       RST_LUMA_DELTAS  = 1'b0;
	localparam logic       RST_FAST_BLEND   = 1'b0;
	localparam logic [6:0] RST_TRANSPARENCY = 7'd10;
	localparam logic       RST_BLEND_ENABLE = 1'b1;

	localparam int T_MAX = 100;

	// floor(x / 3) for x < 1024 as (x * 683) >> 11
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;

	// floor(x / 100) = floor((x >> 2) / 25), (y * 2684355) >> 26 exact for y < 2^21
	localparam int DIV25_MUL   = 2684355;
	localparam int DIV25_MUL_W = 22;
	localparam int DIV25_SHIFT = 26;

	localparam int LUMA_R_W = 2990;
	localparam int LUMA_G_W = 5670;
	localparam int LUMA_B_W = 1140;
	localparam int LUMA_DEN = 10000;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CH_W-1:0]   lut_t [256];

	function automatic lut_t luma_lut(input int unsigned w);
		lut_t tbl;
		for (int i = 0; i < 256; i++) begin
			tbl[i] = 8'((w * i) / LUMA_DEN);
		end
		return tbl;
	endfunction

	localparam lut_t LUMA_R_LUT = luma_lut(LUMA_R_W);
	localparam lut_t LUMA_G_LUT = luma_lut(LUMA_G_W);
	localparam lut_t LUMA_B_LUT = luma_lut(LUMA_B_W);

	typedef struct packed {
		logic       colour_mode;
		logic       luma_deltas;
		logic       fast_blend;
		logic [6:0] transparency;
		logic       blend_enable;
	} cfg_t;

	typedef struct packed {
		logic      req_type;
		idx_t      pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// payload of the product stage
	typedef struct packed {
		idx_t                         idx;
		logic                         is_load;
		logic                         fast;
		logic [PIX_W-1:0]             px;
		logic [LANES-1:0][SUM_W-1:0]  sum;
		logic [LANES-1:0]             ref_we;
		logic [LANES-1:0]             acc_we;
		logic [CH_W-1:0]              delta;
	} s2_t;

	// frame store write, lane-masked
	typedef struct packed {
		logic              valid;
		addr_t             addr;
		logic [LANES-1:0]  ref_we;
		logic [PIX_W-1:0]  ref_data;
		logic [LANES-1:0]  acc_we;
		logic [ACCS_W-1:0] acc_data;
	} wr_t;

endpackage

// ----- rtl/core/fdrb_pix_if.sv -----
// pixel request channel: valid/ready plus request fields
// depends on fdrb_pkg
`timescale 1ns / 1ps
interface fdrb_pix_if;
	logic                valid;
	logic                ready;
	logic                req_type;
	fdrb_pkg::idx_t      pixel_index;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;

	modport source (output valid, req_type, pixel_index, red, green, blue, input ready);
	modport sink (input valid, req_type, pixel_index, red, green, blue, output ready);
endinterface

// ----- rtl/core/fdrb_delta_if.sv -----
// result channel: valid/ready plus the difference byte
// no dependencies
`timescale 1ns / 1ps
interface fdrb_delta_if;
	logic       valid;
	logic       ready;
	logic [7:0] delta;

	modport source (output valid, delta, input ready);
	modport sink (input valid, delta, output ready);
endinterface

// ----- rtl/core/fdrb_cfg.sv -----
// configuration registers with their reset values
// depends on fdrb_pkg
`timescale 1ns / 1ps
module fdrb_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fdrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdrb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fdrb_pkg::cfg_t                   cfg
);

	fdrb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.colour_mode  <= fdrb_pkg::RST_COLOUR_MODE;
			cfg_q.luma_deltas  <= fdrb_pkg::RST_LUMA_DELTAS;
			cfg_q.fast_blend   <= fdrb_pkg::RST_FAST_BLEND;
			cfg_q.transparency <= fdrb_pkg::RST_TRANSPARENCY;
			cfg_q.blend_enable <= fdrb_pkg::RST_BLEND_ENABLE;
		end else if (cfg_we) begin
			case (cfg_index)
				fdrb_pkg::REG_COLOUR_MODE:  cfg_q.colour_mode  <= cfg_data[0];
				fdrb_pkg::REG_LUMA_DELTAS:  cfg_q.luma_deltas  <= cfg_data[0];
				fdrb_pkg::REG_FAST_BLEND:   cfg_q.fast_blend   <= cfg_data[0];
				fdrb_pkg::REG_TRANSPARENCY: cfg_q.transparency <= cfg_data[6:0];
				fdrb_pkg::REG_BLEND_ENABLE: cfg_q.blend_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/fdrb_store.sv -----
// reference and accumulator frame memories, one read and one write port each
// depends on fdrb_pkg; read data merged with the write of the same edge
`timescale 1ns / 1ps
module fdrb_store (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fdrb_pkg::addr_t              raddr,
	input  fdrb_pkg::wr_t                wr,
	output logic [fdrb_pkg::PIX_W-1:0]   rd_ref,
	output logic [fdrb_pkg::ACCS_W-1:0]  rd_acc
);

	logic [fdrb_pkg::PIX_W-1:0]  ref_mem [fdrb_pkg::MEM_DEPTH];
	logic [fdrb_pkg::ACCS_W-1:0] acc_mem [fdrb_pkg::MEM_DEPTH];

	logic [fdrb_pkg::PIX_W-1:0]  rd_ref_q;
	logic [fdrb_pkg::ACCS_W-1:0] rd_acc_q;
	fdrb_pkg::addr_t             raddr_q;
	fdrb_pkg::wr_t               last_q;
	logic                        hit;

	always_ff @(posedge clk) begin
		rd_ref_q <= ref_mem[raddr];
		rd_acc_q <= acc_mem[raddr];
		raddr_q  <= raddr;
		if (wr.valid) begin
			for (int l = 0; l < fdrb_pkg::LANES; l++) begin
				if (wr.ref_we[l])
					ref_mem[wr.addr][l*fdrb_pkg::CH_W +: fdrb_pkg::CH_W] <=
						wr.ref_data[l*fdrb_pkg::CH_W +: fdrb_pkg::CH_W];
				if (wr.acc_we[l])
					acc_mem[wr.addr][l*fdrb_pkg::ACC_W +: fdrb_pkg::ACC_W] <=
						wr.acc_data[l*fdrb_pkg::ACC_W +: fdrb_pkg::ACC_W];
			end
		end
	end

	// the write that lands on the read edge is not in the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else begin
			last_q <= wr;
		end
	end

	assign hit = last_q.valid && (last_q.addr == raddr_q);

	always_comb begin
		for (int l = 0; l < fdrb_pkg::LANES; l++) begin
			rd_ref[l*fdrb_pkg::CH_W +: fdrb_pkg::CH_W] = (hit && last_q.ref_we[l]) ?
				last_q.ref_data[l*fdrb_pkg::CH_W +: fdrb_pkg::CH_W] :
				rd_ref_q[l*fdrb_pkg::CH_W +: fdrb_pkg::CH_W];
			rd_acc[l*fdrb_pkg::ACC_W +: fdrb_pkg::ACC_W] = (hit && last_q.acc_we[l]) ?
				last_q.acc_data[l*fdrb_pkg::ACC_W +: fdrb_pkg::ACC_W] :
				rd_acc_q[l*fdrb_pkg::ACC_W +: fdrb_pkg::ACC_W];
		end
	end

endmodule

// ----- rtl/core/fdrb_front.sv -----
// read stage logic: difference byte, blend products and write masks
// depends on fdrb_pkg (luma tables, reciprocal constants)
`timescale 1ns / 1ps
module fdrb_front (
	input  fdrb_pkg::cfg_t                cfg,
	input  fdrb_pkg::pix_t                item,
	input  logic [fdrb_pkg::PIX_W-1:0]    old_ref,
	input  logic [fdrb_pkg::ACCS_W-1:0]   old_acc,
	output fdrb_pkg::s2_t                 nxt
);

	logic [fdrb_pkg::LANES-1:0]                    lanes;
	logic                                          in_range;
	logic                                          is_load;
	logic [6:0]                                    t;
	logic [6:0]                                    op;
	logic [fdrb_pkg::PIX_W-1:0]                    px;
	logic [fdrb_pkg::LANES-1:0][7:0]               ad;
	logic [fdrb_pkg::LANES-1:0][15:0]              xo;
	logic [fdrb_pkg::LANES-1:0][15:0]              yn;
	logic [fdrb_pkg::LANES-1:0][fdrb_pkg::SUM_W-1:0] sum;
	logic [7:0]                                    new_c;
	logic [7:0]                                    old_c;
	logic [9:0]                                    sum3;
	logic [19:0]                                   prod3;
	logic [7:0]                                    avg;
	logic [7:0]                                    luma;
	logic [7:0]                                    delta;

	always_comb begin
		lanes    = cfg.colour_mode ? 3'b111 : 3'b001;
		in_range = (32'(item.pixel_index) < 32'(fdrb_pkg::FRAME_PIXELS));
		is_load  = (item.req_type == fdrb_pkg::REQ_LOAD);
		t        = (cfg.transparency > 7'(fdrb_pkg::T_MAX)) ? 7'(fdrb_pkg::T_MAX) :
			cfg.transparency;
		op       = 7'(fdrb_pkg::T_MAX) - t;
		px       = {item.blue, item.green, item.red};

		for (int l = 0; l < fdrb_pkg::LANES; l++) begin
			new_c = px[l*8 +: 8];
			old_c = old_ref[l*8 +: 8];
			ad[l] = (old_c > new_c) ? (old_c - new_c) : (new_c - old_c);
			// fast blend works on bytes, slow blend on 8.8 accumulators
			xo[l] = cfg.fast_blend ? {8'd0, old_c} : old_acc[l*16 +: 16];
			yn[l] = cfg.fast_blend ? {8'd0, new_c} : {new_c, 8'd0};
			sum[l] = fdrb_pkg::SUM_W'(24'(xo[l]) * 24'(op) + 24'(yn[l]) * 24'(t));
		end

		sum3  = 10'(ad[0]) + 10'(ad[1]) + 10'(ad[2]);
		prod3 = 20'(sum3) * 20'(fdrb_pkg::DIV3_MUL);
		avg   = prod3[fdrb_pkg::DIV3_SHIFT +: 8];
		luma  = 8'(9'(fdrb_pkg::LUMA_R_LUT[ad[0]]) + 9'(fdrb_pkg::LUMA_G_LUT[ad[1]]) +
			9'(fdrb_pkg::LUMA_B_LUT[ad[2]]));

		if (!in_range || is_load)
			delta = 8'd0;
		else if (!cfg.colour_mode)
			delta = ad[0];
		else if (cfg.luma_deltas)
			delta = luma;
		else
			delta = avg;

		nxt.idx     = item.pixel_index;
		nxt.is_load = is_load;
		nxt.fast    = cfg.fast_blend;
		nxt.px      = px;
		nxt.sum     = sum;
		nxt.delta   = delta;
		if (!in_range) begin
			nxt.ref_we = '0;
			nxt.acc_we = '0;
		end else if (is_load) begin
			nxt.ref_we = lanes;
			nxt.acc_we = lanes;
		end else if (cfg.blend_enable) begin
			nxt.ref_we = lanes;
			nxt.acc_we = cfg.fast_blend ? '0 : lanes;
		end else begin
			nxt.ref_we = '0;
			nxt.acc_we = '0;
		end
	end

endmodule

// ----- rtl/core/frame_delta_reference_blend_top.sv -----
// frame difference engine with a running-average reference frame
// depends on fdrb_pkg, fdrb_pix_if, fdrb_delta_if, fdrb_cfg, fdrb_store, fdrb_front
//
//   channel   dir   handshake       fields
//   pixels    in    valid/ready     req_type, pixel_index, red, green, blue
//   result    out   valid/ready     delta
//   cfg       in    cfg_we          cfg_index, cfg_data
//
// one item per cycle unless a stalled result or a same-index hazard holds the pipe; result valid from s3
// frame store read-modify-write: read on accept, write back as the item leaves s2
// an item to the index of the item just ahead waits in s1 until that one has written back
// async reset clears control and config; frame memories are not cleared
// a stalled result holds the pipe behind it; the input still takes an item while s1 is free
`timescale 1ns / 1ps
`include "frame_delta_reference_blend_top_macros.svh"
module frame_delta_reference_blend_top (
	input  logic                             clk,
	input  logic                             arst_n,
	fdrb_pix_if.sink                         pixels,
	fdrb_delta_if.source                     result,
	input  logic                             cfg_we,
	input  logic [fdrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fdrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fdrb_pkg::cfg_t   cfg;
	fdrb_pkg::pix_t   pix;
	fdrb_pkg::addr_t  raddr;
	fdrb_pkg::wr_t    wr;
	fdrb_pkg::s2_t    front_out;

	logic [fdrb_pkg::PIX_W-1:0]  rd_ref;
	logic [fdrb_pkg::ACCS_W-1:0] rd_acc;

	// pipeline registers
	logic           s1_valid_q;
	fdrb_pkg::pix_t s1_q;
	logic           s2_valid_q;
	fdrb_pkg::s2_t  s2_q;
	logic           s3_valid_q;
	logic [7:0]     s3_delta_q;

	logic in_fire;
	logic s1_adv;
	logic s2_adv;
	logic s2_free;
	logic s2_wr_any;
	logic hazard;

	// divide-by-100 logic, combinational on s2
	logic [fdrb_pkg::LANES-1:0][20:0] div_in;
	logic [fdrb_pkg::LANES-1:0][42:0] div_prod;
	logic [fdrb_pkg::LANES-1:0][15:0] quot;

	fdrb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdrb_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.raddr  (raddr),
		.wr     (wr),
		.rd_ref (rd_ref),
		.rd_acc (rd_acc)
	);

	fdrb_front u_front (
		.cfg     (cfg),
		.item    (s1_q),
		.old_ref (rd_ref),
		.old_acc (rd_acc),
		.nxt     (front_out)
	);

	assign pix.req_type    = pixels.req_type;
	assign pix.pixel_index = pixels.pixel_index;
	assign pix.red         = pixels.red;
	assign pix.green       = pixels.green;
	assign pix.blue        = pixels.blue;

	// handshake and stall chain, back to front
	assign s2_wr_any = (|s2_q.ref_we) || (|s2_q.acc_we);
	assign s2_adv    = s2_valid_q && (!s3_valid_q || result.ready);
	assign s2_free   = !s2_valid_q || s2_adv;
	// s2 writes back at the end of the cycle in which it advances; s1 must not read around it
	assign hazard    = s2_valid_q && s2_wr_any && (s2_q.idx == s1_q.pixel_index);
	assign s1_adv    = s1_valid_q && !hazard && s2_free;
	assign pixels.ready = !s1_valid_q || s1_adv;
	assign in_fire   = pixels.valid && pixels.ready;

	// a held s1 item re-reads its entry every cycle so later writes show up
	assign raddr = (s1_valid_q && !s1_adv) ? s1_q.pixel_index[fdrb_pkg::ADDR_W-1:0] :
		pixels.pixel_index[fdrb_pkg::ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_fire || (s1_valid_q && !s1_adv);
			s2_valid_q <= s1_adv || (s2_valid_q && !s2_adv);
			s3_valid_q <= s2_adv || (s3_valid_q && !result.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			s1_q <= pix;
		if (s1_adv)
			s2_q <= front_out;
		if (s2_adv)
			s3_delta_q <= s2_q.delta;
	end

	// floor(sum / 100) by reciprocal multiply per lane
	always_comb begin
		for (int l = 0; l < fdrb_pkg::LANES; l++) begin
			div_in[l]   = s2_q.sum[l][fdrb_pkg::SUM_W-1:2];
			div_prod[l] = 43'(div_in[l]) * 43'(fdrb_pkg::DIV25_MUL);
			quot[l]     = div_prod[l][fdrb_pkg::DIV25_SHIFT +: 16];
		end
	end

	// write-back record
	always_comb begin
		wr.valid  = s2_adv && s2_wr_any;
		wr.addr   = s2_q.idx[fdrb_pkg::ADDR_W-1:0];
		wr.ref_we = s2_q.ref_we;
		wr.acc_we = s2_q.acc_we;
		for (int l = 0; l < fdrb_pkg::LANES; l++) begin
			if (s2_q.is_load) begin
				wr.ref_data[l*8 +: 8]   = s2_q.px[l*8 +: 8];
				wr.acc_data[l*16 +: 16] = {s2_q.px[l*8 +: 8], 8'd0};
			end else begin
				wr.ref_data[l*8 +: 8]   = s2_q.fast ? quot[l][7:0] : quot[l][15:8];
				wr.acc_data[l*16 +: 16] = quot[l];
			end
		end
	end

	assign result.valid = s3_valid_q;
	assign result.delta = s3_delta_q;

	// an item never passes the write-back of the same entry ahead of it
	`FDRB_ASSERT_IMP(a_no_raw_overtake, clk, arst_n, s1_adv && s2_valid_q && s2_wr_any, s1_q.pixel_index != s2_q.idx, "item overtook write-back of same index")
	// every accepted item lands in the read stage
	`FDRB_ASSERT_NXT(a_accept_lands, clk, arst_n, in_fire, s1_valid_q, "accepted item lost before read stage")
	// load items carry a zero difference
	`FDRB_ASSERT_IMP(a_load_zero_delta, clk, arst_n, s2_valid_q && s2_q.is_load, s2_q.delta == 8'd0, "load item with nonzero delta")

endmodule
